[sv/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// condition must never be seen outside reset
`define CHK_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

[sv/tlca_pkg.sv]
// shared types and codes for the tree lca block
// no dependencies
`timescale 1ns / 1ps

package tlca_pkg;

	localparam int DEF_MAX_NODES    = 1024;
	localparam int DEF_TABLE_LEVELS = 11;
	localparam int ID_W             = 10;
	localparam int DEPTH_W          = 10;
	localparam int CFG_W            = 11;
	localparam int WIDE_W           = 18;

	localparam logic [1:0] OP_EDGE  = 2'd0;
	localparam logic [1:0] OP_BUILD = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_BUILT = 2'd1;
	localparam logic [1:0] ST_BAD_NODE  = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [1:0]      op;
		logic [ID_W-1:0] node_a;
		logic [ID_W-1:0] node_b;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] ancestor;
		logic [1:0]      status;
	} rsp_t;

endpackage

[sv/tlca_ram.sv]
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module tlca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/tree_lca_sparse_table.sv]
// lowest common ancestor by euler tour and sparse table range minimum
// depends on tlca_pkg and tlca_ram
//
// channel   dir  handshake          beat
// req       in   req_valid/ready    op, node_a, node_b
// rsp       out  rsp_valid/ready    ancestor, status
// cfg       in   cfg_we             node_count, no wait
//
// after reset the adjacency heads are swept empty, req_ready low
// build: node_count first-visit slots are cleared, then the tree is walked by descents,
// skips of visited nodes or stale edges, and pops; then level 0 is filled and each higher
// sparse table entry is built from two reads on the one table read port
// one item at a time; a new beat is taken while the previous result waits in rsp
`timescale 1ns / 1ps

module tree_lca_sparse_table #(
	parameter int MAX_NODES    = tlca_pkg::DEF_MAX_NODES,
	parameter int TABLE_LEVELS = tlca_pkg::DEF_TABLE_LEVELS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  tlca_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output tlca_pkg::rsp_t             rsp,
	input  logic                       cfg_we,
	input  logic [tlca_pkg::CFG_W-1:0] cfg_wdata
);
	import tlca_pkg::*;

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int SLOTS  = 2 * MAX_NODES;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int LEN_W  = SLOT_W + 1;
	localparam int CNT_W  = $clog2(MAX_NODES + 1);
	localparam int LVL_W  = $clog2(TABLE_LEVELS);
	localparam int PW     = ((LEN_W > TABLE_LEVELS) ? LEN_W : TABLE_LEVELS) + 1;
	localparam int FR_W   = NODE_W + SLOT_W;
	localparam int TR_W   = NODE_W + DEPTH_W;
	localparam int TB_AW  = LVL_W + SLOT_W;
	localparam logic [SLOT_W-1:0] NIL = SLOT_W'(SLOTS - 1);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_CLR  = 5'd1;
	localparam logic [4:0] S_OUT  = 5'd2;
	localparam logic [4:0] S_E0   = 5'd3;
	localparam logic [4:0] S_E1   = 5'd4;
	localparam logic [4:0] S_E2   = 5'd5;
	localparam logic [4:0] S_E3   = 5'd6;
	localparam logic [4:0] S_BCLR = 5'd7;
	localparam logic [4:0] S_BR0  = 5'd8;
	localparam logic [4:0] S_BR1  = 5'd9;
	localparam logic [4:0] S_WT   = 5'd10;
	localparam logic [4:0] S_WP   = 5'd11;
	localparam logic [4:0] S_WA   = 5'd12;
	localparam logic [4:0] S_WF   = 5'd13;
	localparam logic [4:0] S_WH   = 5'd14;
	localparam logic [4:0] S_T0   = 5'd15;
	localparam logic [4:0] S_TL   = 5'd16;
	localparam logic [4:0] S_T1   = 5'd17;
	localparam logic [4:0] S_T2   = 5'd18;
	localparam logic [4:0] S_T3   = 5'd19;
	localparam logic [4:0] S_T4   = 5'd20;
	localparam logic [4:0] S_Q0   = 5'd21;
	localparam logic [4:0] S_Q1   = 5'd22;
	localparam logic [4:0] S_Q2   = 5'd23;
	localparam logic [4:0] S_Q3   = 5'd24;
	localparam logic [4:0] S_Q4   = 5'd25;
	localparam logic [4:0] S_Q5   = 5'd26;
	localparam logic [4:0] S_Q6   = 5'd27;
	localparam logic [4:0] S_Q7   = 5'd28;

	function automatic logic [PW-1:0] pow2(input logic [LVL_W-1:0] j);
		return PW'(1) << j;
	endfunction

	// floor of log2, capped at the top table level
	function automatic logic [LVL_W-1:0] lvl_of(input logic [LEN_W-1:0] len);
		int k;
		k = 0;
		for (int i = 0; i < LEN_W; i++) begin
			if (len[i]) begin
				k = i;
			end
		end
		if (k > TABLE_LEVELS - 1) begin
			k = TABLE_LEVELS - 1;
		end
		return LVL_W'(k);
	endfunction

	logic [4:0]        state_q;
	logic [ID_W-1:0]   a_q, b_q;
	logic [CNT_W-1:0]  nc_q;
	logic [LEN_W-1:0]  used_q, tlen_q, idx_q;
	logic              ready_q;
	logic [CNT_W-1:0]  sp_q;
	logic [NODE_W-1:0] top_node_q, t_q, nl_q;
	logic [SLOT_W-1:0] top_ptr_q, fa_q, sa_q, sb_q, l_q, r_q;
	logic [LVL_W-1:0]  lvl_q, k_q;
	logic [DEPTH_W-1:0] dl_q;
	logic [ID_W-1:0]   res_anc_q;
	logic [1:0]        res_st_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              hd_we, nx_we, tg_we, fp_we, tr_we, tb_we, sk_we;
	logic [NODE_W-1:0] hd_wa, hd_ra, fp_wa, fp_ra, sk_wa, sk_ra;
	logic [SLOT_W-1:0] nx_wa, nx_ra, tg_wa, tg_ra, tr_wa, tr_ra;
	logic [TB_AW-1:0]  tb_wa, tb_ra;
	logic [SLOT_W-1:0] hd_wd, hd_rd, nx_wd, nx_rd, fp_wd, fp_rd, tb_wd, tb_rd;
	logic [NODE_W-1:0] tg_wd, tg_rd;
	logic [TR_W-1:0]   tr_wd, tr_rd;
	logic [FR_W-1:0]   sk_wd, sk_rd;

	logic [WIDE_W-1:0] nc_w, cfg_w, cfg_clamped;
	logic              a_ok, b_ok, tg_ok, tour_room, can_emit;
	logic [SLOT_W-1:0] half;
	logic [LEN_W-1:0]  qlen;
	logic [SLOT_W-1:0] fb, q_lo, q_hi;
	logic [DEPTH_W-1:0] dr;
	logic [NODE_W-1:0] nr, sk_node;
	logic [SLOT_W-1:0] sk_ptr;

	assign nc_w      = WIDE_W'(nc_q);
	assign a_ok      = WIDE_W'(a_q) < nc_w;
	assign b_ok      = WIDE_W'(b_q) < nc_w;
	assign tg_ok     = WIDE_W'(tg_rd) < nc_w;
	assign tour_room = WIDE_W'(tlen_q) < WIDE_W'(SLOTS);
	assign half      = SLOT_W'(pow2(lvl_q) >> 1);
	assign fb        = fp_rd;
	assign q_lo      = (fa_q > fb) ? fb : fa_q;
	assign q_hi      = (fa_q > fb) ? fa_q : fb;
	assign qlen      = LEN_W'(sb_q) - LEN_W'(sa_q) + LEN_W'(1);
	assign dr        = tr_rd[DEPTH_W-1:0];
	assign nr        = tr_rd[TR_W-1 -: NODE_W];
	assign sk_node   = sk_rd[FR_W-1 -: NODE_W];
	assign sk_ptr    = sk_rd[SLOT_W-1:0];
	assign can_emit  = !rsp_valid_q || rsp_ready;

	assign cfg_w       = WIDE_W'(cfg_wdata);
	assign cfg_clamped = (cfg_w == '0) ? WIDE_W'(1) :
		((cfg_w > WIDE_W'(MAX_NODES)) ? WIDE_W'(MAX_NODES) : cfg_w);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// memory port steering
	always_comb begin
		hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_ra = '0;
		nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_ra = '0;
		tg_we = 1'b0; tg_wa = '0; tg_wd = '0; tg_ra = '0;
		fp_we = 1'b0; fp_wa = '0; fp_wd = '0; fp_ra = '0;
		tr_we = 1'b0; tr_wa = '0; tr_wd = '0; tr_ra = '0;
		tb_we = 1'b0; tb_wa = '0; tb_wd = '0; tb_ra = '0;
		sk_we = 1'b0; sk_wa = '0; sk_wd = '0; sk_ra = '0;
		case (state_q)
			S_CLR: begin
				hd_we = 1'b1;
				hd_wa = idx_q[NODE_W-1:0];
				hd_wd = NIL;
			end
			S_E0: begin
				hd_ra = NODE_W'(a_q);
			end
			S_E1: begin
				nx_we = 1'b1; nx_wa = used_q[SLOT_W-1:0]; nx_wd = hd_rd;
				tg_we = 1'b1; tg_wa = used_q[SLOT_W-1:0]; tg_wd = NODE_W'(b_q);
				hd_we = 1'b1; hd_wa = NODE_W'(a_q); hd_wd = used_q[SLOT_W-1:0];
			end
			S_E2: begin
				hd_ra = NODE_W'(b_q);
			end
			S_E3: begin
				nx_we = 1'b1; nx_wa = used_q[SLOT_W-1:0] + SLOT_W'(1); nx_wd = hd_rd;
				tg_we = 1'b1; tg_wa = used_q[SLOT_W-1:0] + SLOT_W'(1);
				tg_wd = NODE_W'(a_q);
				hd_we = 1'b1; hd_wa = NODE_W'(b_q);
				hd_wd = used_q[SLOT_W-1:0] + SLOT_W'(1);
			end
			S_BCLR: begin
				fp_we = 1'b1; fp_wa = idx_q[NODE_W-1:0]; fp_wd = NIL;
			end
			S_BR0: begin
				fp_we = 1'b1; fp_wa = '0; fp_wd = '0;
				tr_we = 1'b1; tr_wa = '0; tr_wd = '0;
				hd_ra = '0;
			end
			S_WT: begin
				nx_ra = top_ptr_q;
				tg_ra = top_ptr_q;
				sk_ra = NODE_W'(sp_q - CNT_W'(2));
			end
			S_WP: begin
				tr_we = tour_room;
				tr_wa = tlen_q[SLOT_W-1:0];
				tr_wd = {sk_node, DEPTH_W'(sp_q - CNT_W'(1))};
			end
			S_WA: begin
				fp_ra = tg_rd;
			end
			S_WF: begin
				if (fp_rd == NIL && WIDE_W'(sp_q) < WIDE_W'(MAX_NODES)) begin
					fp_we = 1'b1; fp_wa = t_q; fp_wd = tlen_q[SLOT_W-1:0];
					tr_we = tour_room; tr_wa = tlen_q[SLOT_W-1:0];
					tr_wd = {t_q, DEPTH_W'(sp_q)};
					sk_we = 1'b1; sk_wa = NODE_W'(sp_q - CNT_W'(1));
					sk_wd = {top_node_q, top_ptr_q};
					hd_ra = t_q;
				end
			end
			S_T0: begin
				tb_we = 1'b1;
				tb_wa = {LVL_W'(0), idx_q[SLOT_W-1:0]};
				tb_wd = idx_q[SLOT_W-1:0];
			end
			S_T1: begin
				tb_ra = {lvl_q - LVL_W'(1), idx_q[SLOT_W-1:0]};
			end
			S_T2: begin
				tb_ra = {lvl_q - LVL_W'(1), idx_q[SLOT_W-1:0] + half};
				tr_ra = tb_rd;
			end
			S_T3: begin
				tr_ra = tb_rd;
			end
			S_T4: begin
				tb_we = 1'b1;
				tb_wa = {lvl_q, idx_q[SLOT_W-1:0]};
				tb_wd = (dl_q < dr) ? l_q : r_q;
			end
			S_Q0: begin
				fp_ra = NODE_W'(a_q);
			end
			S_Q1: begin
				fp_ra = NODE_W'(b_q);
			end
			S_Q4: begin
				tb_ra = {k_q, sa_q};
			end
			S_Q5: begin
				tb_ra = {k_q, SLOT_W'(PW'(sb_q) + PW'(1) - pow2(k_q))};
				tr_ra = tb_rd;
			end
			S_Q6: begin
				tr_ra = tb_rd;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			a_q        <= '0;
			b_q        <= '0;
			nc_q       <= CNT_W'(1);
			used_q     <= '0;
			tlen_q     <= '0;
			idx_q      <= '0;
			ready_q    <= 1'b0;
			sp_q       <= '0;
			top_node_q <= '0;
			top_ptr_q  <= '0;
			t_q        <= '0;
			nl_q       <= '0;
			fa_q       <= '0;
			sa_q       <= '0;
			sb_q       <= '0;
			l_q        <= '0;
			r_q        <= '0;
			lvl_q      <= '0;
			k_q        <= '0;
			dl_q       <= '0;
			res_anc_q  <= '0;
			res_st_q   <= ST_OK;
		end else begin
			case (state_q)
				S_CLR: begin
					idx_q <= idx_q + LEN_W'(1);
					if (idx_q == LEN_W'(MAX_NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						a_q       <= req.node_a;
						b_q       <= req.node_b;
						idx_q     <= '0;
						res_anc_q <= '0;
						res_st_q  <= ST_OK;
						case (req.op)
							OP_EDGE:  state_q <= S_E0;
							OP_BUILD: state_q <= S_BCLR;
							OP_QUERY: state_q <= S_Q0;
							default:  state_q <= S_OUT;
						endcase
					end
				end
				S_OUT: begin
					if (can_emit) begin
						state_q <= S_IDLE;
					end
				end
				S_E0: begin
					if (!a_ok || !b_ok) begin
						res_st_q <= ST_BAD_NODE;
						state_q  <= S_OUT;
					end else if (WIDE_W'(used_q) + WIDE_W'(2) > WIDE_W'(SLOTS - 2)) begin
						res_st_q <= ST_FULL;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_E1;
					end
				end
				S_E1: state_q <= S_E2;
				S_E2: state_q <= S_E3;
				S_E3: begin
					used_q  <= used_q + LEN_W'(2);
					ready_q <= 1'b0;
					state_q <= S_OUT;
				end
				S_BCLR: begin
					idx_q <= idx_q + LEN_W'(1);
					if (WIDE_W'(idx_q) + WIDE_W'(1) == nc_w) begin
						state_q <= S_BR0;
					end
				end
				S_BR0: begin
					tlen_q  <= LEN_W'(1);
					state_q <= S_BR1;
				end
				S_BR1: begin
					top_node_q <= '0;
					top_ptr_q  <= hd_rd;
					sp_q       <= CNT_W'(1);
					state_q    <= S_WT;
				end
				S_WT: begin
					if (top_ptr_q >= NIL) begin
						sp_q <= sp_q - CNT_W'(1);
						if (sp_q == CNT_W'(1)) begin
							idx_q   <= '0;
							state_q <= S_T0;
						end else begin
							state_q <= S_WP;
						end
					end else begin
						state_q <= S_WA;
					end
				end
				S_WP: begin
					// frame below the popped one comes back to the top registers
					top_node_q <= sk_node;
					top_ptr_q  <= sk_ptr;
					if (tour_room) begin
						tlen_q <= tlen_q + LEN_W'(1);
					end
					state_q <= S_WT;
				end
				S_WA: begin
					top_ptr_q <= nx_rd;
					t_q       <= tg_rd;
					// stale targets are skipped
					state_q   <= tg_ok ? S_WF : S_WT;
				end
				S_WF: begin
					if (fp_rd == NIL && WIDE_W'(sp_q) < WIDE_W'(MAX_NODES)) begin
						if (tour_room) begin
							tlen_q <= tlen_q + LEN_W'(1);
						end
						state_q <= S_WH;
					end else begin
						state_q <= S_WT;
					end
				end
				S_WH: begin
					top_node_q <= t_q;
					top_ptr_q  <= hd_rd;
					sp_q       <= sp_q + CNT_W'(1);
					state_q    <= S_WT;
				end
				S_T0: begin
					idx_q <= idx_q + LEN_W'(1);
					if (idx_q + LEN_W'(1) == tlen_q) begin
						lvl_q   <= LVL_W'(1);
						state_q <= S_TL;
					end
				end
				S_TL: begin
					idx_q <= '0;
					if (pow2(lvl_q) <= PW'(tlen_q)) begin
						state_q <= S_T1;
					end else begin
						ready_q <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_T1: state_q <= S_T2;
				S_T2: begin
					l_q     <= tb_rd;
					state_q <= S_T3;
				end
				S_T3: begin
					r_q     <= tb_rd;
					dl_q    <= dr;
					state_q <= S_T4;
				end
				S_T4: begin
					if (PW'(idx_q) + PW'(1) + pow2(lvl_q) <= PW'(tlen_q)) begin
						idx_q   <= idx_q + LEN_W'(1);
						state_q <= S_T1;
					end else if (int'(lvl_q) + 1 < TABLE_LEVELS) begin
						lvl_q   <= lvl_q + LVL_W'(1);
						state_q <= S_TL;
					end else begin
						ready_q <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_Q0: begin
					if (!ready_q) begin
						res_st_q <= ST_NOT_BUILT;
						state_q  <= S_OUT;
					end else if (!a_ok || !b_ok) begin
						res_st_q <= ST_BAD_NODE;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_Q1;
					end
				end
				S_Q1: begin
					fa_q    <= fp_rd;
					state_q <= S_Q2;
				end
				S_Q2: begin
					if (fa_q == NIL || fb == NIL) begin
						res_st_q <= ST_BAD_NODE;
						state_q  <= S_OUT;
					end else begin
						sa_q    <= q_lo;
						sb_q    <= q_hi;
						state_q <= S_Q3;
					end
				end
				S_Q3: begin
					k_q     <= lvl_of(qlen);
					state_q <= S_Q4;
				end
				S_Q4: state_q <= S_Q5;
				S_Q5: begin
					l_q     <= tb_rd;
					state_q <= S_Q6;
				end
				S_Q6: begin
					r_q     <= tb_rd;
					dl_q    <= dr;
					nl_q    <= nr;
					state_q <= S_Q7;
				end
				S_Q7: begin
					// ties go to the left end of the range
					res_anc_q <= ID_W'((dl_q <= dr) ? nl_q : nr);
					state_q   <= S_OUT;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_we) begin
				nc_q    <= CNT_W'(cfg_clamped);
				ready_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (state_q == S_OUT && can_emit) begin
			rsp_valid_q    <= 1'b1;
			rsp_q.ancestor <= res_anc_q;
			rsp_q.status   <= res_st_q;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	tlca_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_NODES)) u_head (
		.clk(clk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd)
	);

	tlca_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd)
	);

	tlca_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_target (
		.clk(clk), .we(tg_we), .waddr(tg_wa), .wdata(tg_wd), .raddr(tg_ra), .rdata(tg_rd)
	);

	tlca_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_NODES)) u_first (
		.clk(clk), .we(fp_we), .waddr(fp_wa), .wdata(fp_wd), .raddr(fp_ra), .rdata(fp_rd)
	);

	tlca_ram #(.WIDTH(TR_W), .DEPTH(SLOTS)) u_tour (
		.clk(clk), .we(tr_we), .waddr(tr_wa), .wdata(tr_wd), .raddr(tr_ra), .rdata(tr_rd)
	);

	// one power-of-two row per level, addressed as {level, position}
	tlca_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_LEVELS * (1 << SLOT_W))) u_table (
		.clk(clk), .we(tb_we), .waddr(tb_wa), .wdata(tb_wd), .raddr(tb_ra), .rdata(tb_rd)
	);

	tlca_ram #(.WIDTH(FR_W), .DEPTH(MAX_NODES)) u_stack (
		.clk(clk), .we(sk_we), .waddr(sk_wa), .wdata(sk_wd), .raddr(sk_ra), .rdata(sk_rd)
	);

endmodule

[sv/tlca_chk.sv]
// port level checker for the tree lca block, bound to the top level
// depends on tlca_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlca_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input tlca_pkg::req_t             req,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input tlca_pkg::rsp_t             rsp,
	input logic                       cfg_we
);
	import tlca_pkg::*;

	logic [1:0] pend_q;
	logic       in_beat, out_beat;

	assign in_beat  = req_valid && req_ready;
	assign out_beat = rsp_valid && rsp_ready;

	// beats taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_beat) - 2'(out_beat);
		end
	end

	`CHK_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "rsp changed while stalled")
	`CHK_NEVER(a_err_zero, clk, arst_n, rsp_valid && rsp.status != ST_OK && rsp.ancestor != '0, "error beat with nonzero ancestor")
	`CHK_NEVER(a_rsp_orphan, clk, arst_n, rsp_valid && pend_q == 2'd0, "rsp beat with no request pending")
	`CHK_NEVER(a_pend_over, clk, arst_n, pend_q == 2'd3 || (cfg_we && pend_q != 2'd0), "too many beats in flight or config while busy")
	`CHK_ASSERT(a_busy_after, clk, arst_n, in_beat |=> !req_ready, "request taken back to back")

endmodule

bind tree_lca_sparse_table tlca_chk u_chk (.*);
